// File: rtl/spp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spp_pkg
// Shared types and constants for the stereo point projection block.
// ----------------------------------------------------------------------------
package spp_pkg;

  typedef enum logic [2:0] {
    REG_ROT0,
    REG_ROT1,
    REG_ROT2,
    REG_TRANS,
    REG_FOCAL_U,
    REG_FOCAL_V,
    REG_PRINC,
    REG_BASE
  } reg_idx_e;

  typedef struct packed {
    logic [53:0] rot0;
    logic [53:0] rot1;
    logic [53:0] rot2;
    logic [62:0] trans;
    logic [31:0] focal_u;
    logic [31:0] focal_v;
    logic [31:0] princ;
    logic [31:0] baseline;
  } cfg_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  localparam int unsigned APB_AW     = 6;
  localparam int unsigned APB_DW     = 64;
  localparam int unsigned COEF_W     = 18;
  localparam int unsigned TRANS_W    = 21;
  localparam int unsigned TRANS_FRAC = 8;
  localparam int unsigned ROT_FRAC   = 16;
  localparam int unsigned KW         = 32;
  localparam int unsigned DISP_W     = 32;
  localparam int unsigned PP_W       = 16;

endpackage

// File: rtl/spp_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spp_cfg
// APB register file holding rotation, translation and camera parameters.
// ----------------------------------------------------------------------------
module spp_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [spp_pkg::APB_AW-1:0]      paddr,
  input  logic [spp_pkg::APB_DW-1:0]      pwdata,
  output logic [spp_pkg::APB_DW-1:0]      prdata,
  output logic                            pready,
  output spp_pkg::cfg_t                   cfg_o
);

  spp_pkg::cfg_t     cfg_q;
  spp_pkg::reg_idx_e idx;
  logic              wr;

  assign idx    = spp_pkg::reg_idx_e'(paddr[5:3]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rot0     <= 54'd65536;
      cfg_q.rot1     <= 54'd65536 << 18;
      cfg_q.rot2     <= 54'd65536 << 36;
      cfg_q.trans    <= '0;
      cfg_q.focal_u  <= 32'd65536;
      cfg_q.focal_v  <= 32'd65536;
      cfg_q.princ    <= '0;
      cfg_q.baseline <= 32'd65536;
    end else if (wr) begin
      case (idx)
        spp_pkg::REG_ROT0:    cfg_q.rot0     <= pwdata[53:0];
        spp_pkg::REG_ROT1:    cfg_q.rot1     <= pwdata[53:0];
        spp_pkg::REG_ROT2:    cfg_q.rot2     <= pwdata[53:0];
        spp_pkg::REG_TRANS:   cfg_q.trans    <= pwdata[62:0];
        spp_pkg::REG_FOCAL_U: cfg_q.focal_u  <= pwdata[31:0];
        spp_pkg::REG_FOCAL_V: cfg_q.focal_v  <= pwdata[31:0];
        spp_pkg::REG_PRINC:   cfg_q.princ    <= pwdata[31:0];
        spp_pkg::REG_BASE:    cfg_q.baseline <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      spp_pkg::REG_ROT0:    prdata = 64'(cfg_q.rot0);
      spp_pkg::REG_ROT1:    prdata = 64'(cfg_q.rot1);
      spp_pkg::REG_ROT2:    prdata = 64'(cfg_q.rot2);
      spp_pkg::REG_TRANS:   prdata = 64'(cfg_q.trans);
      spp_pkg::REG_FOCAL_U: prdata = 64'(cfg_q.focal_u);
      spp_pkg::REG_FOCAL_V: prdata = 64'(cfg_q.focal_v);
      spp_pkg::REG_PRINC:   prdata = 64'(cfg_q.princ);
      spp_pkg::REG_BASE:    prdata = 64'(cfg_q.baseline);
      default:              prdata = '0;
    endcase
  end

endmodule

// File: rtl/spp_xform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spp_xform
// Three-stage translate and rotate pipeline: add, multiply, sum and round.
// ----------------------------------------------------------------------------
module spp_xform #(
  parameter int unsigned W = 32,
  parameter int unsigned F = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [W-1:0]  x_i,
  input  logic signed [W-1:0]  y_i,
  input  logic signed [W-1:0]  z_i,
  input  spp_pkg::rgb_t        rgb_i,
  input  spp_pkg::cfg_t        cfg_i,
  output logic                 valid_o,
  output logic signed [W-1:0]  rc_o [3],
  output spp_pkg::rgb_t        rgb_o
);

  localparam int unsigned TSH = F - spp_pkg::TRANS_FRAC;
  localparam int unsigned SW  = ((W > spp_pkg::TRANS_W + TSH) ? W : spp_pkg::TRANS_W + TSH) + 1;
  localparam int unsigned PW  = SW + spp_pkg::COEF_W;
  localparam int unsigned AW  = PW + 2;

  logic signed [W-1:0]  p [3];
  logic [53:0]          rows [3];
  logic signed [SW-1:0] s_d [3], s_q [3];
  logic signed [PW-1:0] m_d [3][3], m_q [3][3];
  logic signed [W-1:0]  rc_d [3], rc_q [3];
  logic [2:0]           v_q;
  spp_pkg::rgb_t        rgb1_q, rgb2_q, rgb3_q;

  assign p[0]    = x_i;
  assign p[1]    = y_i;
  assign p[2]    = z_i;
  assign rows[0] = cfg_i.rot0;
  assign rows[1] = cfg_i.rot1;
  assign rows[2] = cfg_i.rot2;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      s_d[j] = SW'(p[j]) +
               (SW'($signed(cfg_i.trans[spp_pkg::TRANS_W*j +: spp_pkg::TRANS_W])) <<< TSH);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        m_d[i][j] = PW'($signed(rows[i][spp_pkg::COEF_W*j +: spp_pkg::COEF_W])) *
                    PW'(s_q[j]);
      end
    end
  end

  always_comb begin
    logic signed [AW-1:0] acc;
    logic signed [AW-1:0] sh;
    logic [AW-W:0]        hi;
    for (int i = 0; i < 3; i++) begin
      acc = AW'(m_q[i][0]) + AW'(m_q[i][1]) + AW'(m_q[i][2]) +
            (AW'(1) <<< (spp_pkg::ROT_FRAC - 1));
      sh  = acc >>> spp_pkg::ROT_FRAC;
      hi  = sh[AW-1:W-1];
      if ((&hi) | ~(|hi)) begin
        rc_d[i] = sh[W-1:0];
      end else if (sh[AW-1]) begin
        rc_d[i] = {1'b1, {(W-1){1'b0}}};
      end else begin
        rc_d[i] = {1'b0, {(W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q    <= s_d;
      m_q    <= m_d;
      rc_q   <= rc_d;
      rgb1_q <= rgb_i;
      rgb2_q <= rgb1_q;
      rgb3_q <= rgb2_q;
    end
  end

  assign valid_o = v_q[2];
  assign rc_o    = rc_q;
  assign rgb_o   = rgb3_q;

endmodule

// File: rtl/spp_proj.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spp_proj
// Numerator setup, three-lane pipelined restoring divider, rounding,
// saturation and the output register.
// ----------------------------------------------------------------------------
module spp_proj #(
  parameter int unsigned W = 32,
  parameter int unsigned F = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [W-1:0]  rc_i [3],
  input  spp_pkg::rgb_t        rgb_i,
  input  spp_pkg::cfg_t        cfg_i,
  output logic                 valid_o,
  output logic signed [W-1:0]  u_o,
  output logic signed [W-1:0]  v_o,
  output logic [spp_pkg::DISP_W-1:0] disp_o,
  output spp_pkg::rgb_t        rgb_o,
  output logic                 dv_o
);

  localparam int unsigned MW  = (W + spp_pkg::KW > 2 * spp_pkg::KW) ? W + spp_pkg::KW
                                                                     : 2 * spp_pkg::KW;
  localparam int unsigned NW  = MW + F;
  localparam int unsigned DW  = W + spp_pkg::ROT_FRAC - 1;
  localparam int unsigned QM0 = (W > F + spp_pkg::PP_W) ? W : F + spp_pkg::PP_W;
  localparam int unsigned QB  = ((QM0 > spp_pkg::DISP_W) ? QM0 : spp_pkg::DISP_W) + 2;
  localparam int unsigned XW  = QB + 3;

  typedef struct packed {
    spp_pkg::rgb_t rgb;
    logic          dok;
    logic [2:0]    neg;
    logic [2:0]    ovf;
  } side_t;

  // setup stage
  logic          v4_q;
  logic [MW-1:0] num_q [3];
  logic [DW-1:0] den4_q;
  side_t         side4_q;
  logic [W-1:0]  mag0, mag1;

  assign mag0 = rc_i[0][W-1] ? unsigned'(-rc_i[0]) : unsigned'(rc_i[0]);
  assign mag1 = rc_i[1][W-1] ? unsigned'(-rc_i[1]) : unsigned'(rc_i[1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en_i) begin
      v4_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q[0]    <= MW'(cfg_i.focal_u) * MW'(cfg_i.baseline);
      num_q[1]    <= MW'(mag0) * MW'(cfg_i.focal_u);
      num_q[2]    <= MW'(mag1) * MW'(cfg_i.focal_v);
      den4_q      <= DW'(rc_i[2][W-2:0]) << spp_pkg::ROT_FRAC;
      side4_q.rgb <= rgb_i;
      side4_q.dok <= (rc_i[2] > 0);
      side4_q.neg <= {rc_i[1][W-1], rc_i[0][W-1], 1'b0};
      side4_q.ovf <= '0;
    end
  end

  // divider stage arrays: entry 0 is after the overflow check
  logic          v_q    [QB+1];
  logic [NW-1:0] rem_q  [QB+1][3];
  logic [QB-1:0] quo_q  [QB+1][3];
  logic [DW-1:0] den_q  [QB+1];
  side_t         side_q [QB+1];
  side_t         side_d;

  always_comb begin
    side_d = side4_q;
    for (int l = 0; l < 3; l++) begin
      side_d.ovf[l] = ((NW'(num_q[l]) << F) >> QB) >= NW'(den4_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 3; l++) begin
        rem_q[0][l] <= NW'(num_q[l]) << F;
        quo_q[0][l] <= '0;
      end
      den_q[0]  <= den4_q;
      side_q[0] <= side_d;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_stage
    localparam int unsigned BIT = QB - 1 - k;
    logic [NW-1:0] rem_d [3];
    logic [QB-1:0] quo_d [3];

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        if ((rem_q[k][l] >> BIT) >= NW'(den_q[k])) begin
          rem_d[l] = rem_q[k][l] - (NW'(den_q[k]) << BIT);
          quo_d[l] = quo_q[k][l] | (QB'(1) << BIT);
        end else begin
          rem_d[l] = rem_q[k][l];
          quo_d[l] = quo_q[k][l];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= rem_d;
        quo_q[k+1]  <= quo_d;
        den_q[k+1]  <= den_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  // round, saturate, register the result
  logic                       vo_q;
  logic signed [W-1:0]        u_q, v_q_out;
  logic [spp_pkg::DISP_W-1:0] disp_q;
  spp_pkg::rgb_t              rgbo_q;
  logic                       dv_q;
  logic [QB:0]                mag [3];
  logic signed [W-1:0]        pix [2];
  logic [spp_pkg::DISP_W-1:0] disp_d;

  always_comb begin
    logic [DW:0]         r2;
    logic signed [XW-1:0] base;
    logic signed [XW-1:0] px;
    logic [XW-W:0]        hi;
    for (int l = 0; l < 3; l++) begin
      r2 = {rem_q[QB][l][DW-1:0], 1'b0};
      if (side_q[QB].ovf[l]) begin
        mag[l] = (QB+1)'(1) << QB;
      end else begin
        mag[l] = (QB+1)'(quo_q[QB][l]) + (QB+1)'(r2 >= (DW+1)'(den_q[QB]));
      end
    end
    disp_d = (|mag[0][QB:spp_pkg::DISP_W]) ? '1 : mag[0][spp_pkg::DISP_W-1:0];
    for (int l = 0; l < 2; l++) begin
      base = (l == 0) ? XW'(cfg_i.princ[spp_pkg::PP_W-1:0]) <<< F
                      : XW'(cfg_i.princ[2*spp_pkg::PP_W-1:spp_pkg::PP_W]) <<< F;
      if (side_q[QB].neg[l+1]) begin
        px = base + $signed(XW'(mag[l+1]));
      end else begin
        px = base - $signed(XW'(mag[l+1]));
      end
      hi = px[XW-1:W-1];
      if ((&hi) | ~(|hi)) begin
        pix[l] = px[W-1:0];
      end else if (px[XW-1]) begin
        pix[l] = {1'b1, {(W-1){1'b0}}};
      end else begin
        pix[l] = {1'b0, {(W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= v_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rgbo_q <= side_q[QB].rgb;
      dv_q   <= side_q[QB].dok;
      if (side_q[QB].dok) begin
        u_q     <= pix[0];
        v_q_out <= pix[1];
        disp_q  <= disp_d;
      end else begin
        u_q     <= '0;
        v_q_out <= '0;
        disp_q  <= '0;
      end
    end
  end

  assign valid_o = vo_q;
  assign u_o     = u_q;
  assign v_o     = v_q_out;
  assign disp_o  = disp_q;
  assign rgb_o   = rgbo_q;
  assign dv_o    = dv_q;

endmodule

// File: rtl/stereo_point_projection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_point_projection
// Stereo pinhole projection of coloured 3D points with disparity output.
// ----------------------------------------------------------------------------
// One point enters per cycle while the pipeline is not held. The three-lane
// restoring divider resolves one quotient bit per stage, QB bits in all, where
// QB is max(COORD_WIDTH, FRAC_BITS + 16, 32) + 2. The whole pipeline advances
// together; it holds when a result waits at the output and result_ready_i is
// low. Configure through the APB port only while no point is in flight.
module stereo_point_projection #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [spp_pkg::APB_AW-1:0]      paddr,
  input  logic [spp_pkg::APB_DW-1:0]      pwdata,
  output logic [spp_pkg::APB_DW-1:0]      prdata,
  output logic                            pready,
  input  logic                            point_valid_i,
  output logic                            point_ready_o,
  input  logic signed [COORD_WIDTH-1:0]   point_x_i,
  input  logic signed [COORD_WIDTH-1:0]   point_y_i,
  input  logic signed [COORD_WIDTH-1:0]   point_z_i,
  input  logic [7:0]                      red_in_i,
  input  logic [7:0]                      green_in_i,
  input  logic [7:0]                      blue_in_i,
  output logic                            result_valid_o,
  input  logic                            result_ready_i,
  output logic signed [COORD_WIDTH-1:0]   pixel_u_o,
  output logic signed [COORD_WIDTH-1:0]   pixel_v_o,
  output logic [spp_pkg::DISP_W-1:0]      disparity_o,
  output logic [7:0]                      red_out_o,
  output logic [7:0]                      green_out_o,
  output logic [7:0]                      blue_out_o,
  output logic                            depth_valid_o
);

  spp_pkg::cfg_t           cfg;
  spp_pkg::rgb_t           rgb_in, rgb_x, rgb_out;
  logic                    en, xv;
  logic signed [COORD_WIDTH-1:0] rc [3];

  // advance everything unless a result is held at the output
  assign en            = ~result_valid_o | result_ready_i;
  assign point_ready_o = en;
  assign rgb_in        = '{r: red_in_i, g: green_in_i, b: blue_in_i};

  spp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  spp_xform #(.W(COORD_WIDTH), .F(FRAC_BITS)) u_xform (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (point_valid_i),
    .x_i     (point_x_i),
    .y_i     (point_y_i),
    .z_i     (point_z_i),
    .rgb_i   (rgb_in),
    .cfg_i   (cfg),
    .valid_o (xv),
    .rc_o    (rc),
    .rgb_o   (rgb_x)
  );

  spp_proj #(.W(COORD_WIDTH), .F(FRAC_BITS)) u_proj (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (xv),
    .rc_i    (rc),
    .rgb_i   (rgb_x),
    .cfg_i   (cfg),
    .valid_o (result_valid_o),
    .u_o     (pixel_u_o),
    .v_o     (pixel_v_o),
    .disp_o  (disparity_o),
    .rgb_o   (rgb_out),
    .dv_o    (depth_valid_o)
  );

  assign red_out_o   = rgb_out.r;
  assign green_out_o = rgb_out.g;
  assign blue_out_o  = rgb_out.b;

endmodule

// File: rtl/spp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spp_checker
// Port-level assertions for the stereo point projection block.
// ----------------------------------------------------------------------------
module spp_checker #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          pready,
  input logic                          point_ready_o,
  input logic                          result_valid_o,
  input logic                          result_ready_i,
  input logic [COORD_WIDTH-1:0]        pixel_u_o,
  input logic [COORD_WIDTH-1:0]        pixel_v_o,
  input logic [spp_pkg::DISP_W-1:0]    disparity_o,
  input logic                          depth_valid_o
);

  a_hold_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_ready_i |=> result_valid_o)
    else $error("result valid dropped while stalled");

  a_hold_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_ready_i |=>
      $stable(pixel_u_o) && $stable(pixel_v_o) && $stable(disparity_o))
    else $error("result payload changed while stalled");

  a_zero_bad_depth : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !depth_valid_o |->
      pixel_u_o == '0 && pixel_v_o == '0 && disparity_o == '0)
    else $error("outputs not zeroed for non-positive depth");

  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !result_valid_o |-> point_ready_o)
    else $error("input stalled with empty output");

  a_pready : assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind stereo_point_projection spp_checker #(.COORD_WIDTH(COORD_WIDTH)) u_spp_checker (.*);
